>>> hw/rtl/imhq_pkg.sv
// shared types and codes for the indexed min-heap queue
package imhq_pkg;

	localparam int IdWidth = 6;
	localparam int IdCount = 64;

	typedef enum logic [1:0] {
		KIND_PUSH     = 2'd0,
		KIND_POP      = 2'd1,
		KIND_REMOVE   = 2'd2,
		KIND_DECREASE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_EMPTY      = 3'd1,
		ST_FULL       = 3'd2,
		ST_ABSENT     = 3'd3,
		ST_PRESENT    = 3'd4,
		ST_NOT_SMALLER = 3'd5
	} status_t;

endpackage

>>> hw/rtl/imhq_slot_ram.sv
// heap slot memory: one write port, two registered read ports
module imhq_slot_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 38
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [DW-1:0] rdata_a,
	output logic [DW-1:0] rdata_b
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

>>> hw/rtl/imhq_pos_ram.sv
// identifier to slot map memory, one write and one registered read port
module imhq_pos_ram #(
	parameter int AW = 6
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [imhq_pkg::IdWidth-1:0] waddr,
	input  logic [AW-1:0]                wdata,
	input  logic [imhq_pkg::IdWidth-1:0] raddr,
	output logic [AW-1:0]                rdata
);

	logic [AW-1:0] mem [imhq_pkg::IdCount];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/indexed_min_heap_queue.sv
// top level of the indexed min-heap queue: sequencer around slot and map memories
// One item at a time. An item first looks up its identifier: the presence bit, then
// the slot map, then the target and last slots. An entry that has to move is written
// back first. For each level it climbs or sinks, the block then reads the parent or
// both children, compares and writes the other entry into the current slot, then writes
// the moving entry one level on. The slot memory has a single write port, so the swap
// takes two writes. The result sits in an output register, so the next item is taken
// while it waits; the input stalls only while an item is in flight.
module indexed_min_heap_queue #(
	parameter int CAPACITY  = 64,
	parameter int KEY_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           kind,
	input  logic [5:0]           ident,
	input  logic [31:0]          key,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           status,
	output logic [5:0]           out_ident,
	output logic [31:0]          out_key,
	output logic [6:0]           occupancy
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = imhq_pkg::IdWidth;
	localparam int DW = KEY_WIDTH + IW;

	typedef enum logic [3:0] {
		S_IDLE, S_LOOK, S_LOOK2, S_LAST, S_FILL,
		S_UP_RD, S_UP_CMP, S_UP_W2,
		S_DN_RD, S_DN_CMP, S_DN_W2, S_DONE
	} state_t;

	state_t state_q;

	imhq_pkg::kind_t     kind_q;
	logic [IW-1:0]       id_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [CW-1:0]       cnt_q;
	logic [imhq_pkg::IdCount-1:0] present_q;
	logic [AW-1:0]       pos_q;   // current slot of the moving entry
	logic [DW-1:0]       ent_q;   // moving entry (ident, key)
	logic [AW-1:0]       oth_pos_q;
	logic                do_down_q;

	imhq_pkg::status_t   status_q;
	logic [IW-1:0]       rid_q;
	logic [31:0]         rkey_q;

	logic                out_valid_q;
	logic [2:0]          res_status_q;
	logic [IW-1:0]       res_ident_q;
	logic [31:0]         res_key_q;
	logic [6:0]          res_occ_q;
	logic                out_free;

	// memory ports
	logic                we;
	logic [AW-1:0]       waddr, ra_a, ra_b;
	logic [DW-1:0]       wdata, rd_a, rd_b;
	logic                pwe;
	logic [IW-1:0]       pwaddr;
	logic [AW-1:0]       pwdata, prd;

	imhq_slot_ram #(.DEPTH(CAPACITY), .AW(AW), .DW(DW)) u_slots (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr_a(ra_a), .raddr_b(ra_b), .rdata_a(rd_a), .rdata_b(rd_b)
	);

	imhq_pos_ram #(.AW(AW)) u_pos (
		.clk(clk), .we(pwe), .waddr(pwaddr), .wdata(pwdata),
		.raddr(id_q), .rdata(prd)
	);

	logic [CW:0]      left_w, right_w;
	logic [AW-1:0]    parent_w;
	logic [CW-1:0]    last_w;
	logic [KEY_WIDTH-1:0] ka, kb, kent;
	logic             up_swap, dn_right, dn_swap;
	logic [DW-1:0]    dn_child;

	assign left_w   = {CW'(pos_q), 1'b1};
	assign right_w  = left_w + 1'b1;
	assign parent_w = AW'((pos_q - 1'b1) >> 1);
	assign last_w   = cnt_q - 1'b1;
	assign ka   = rd_a[KEY_WIDTH-1:0];
	assign kb   = rd_b[KEY_WIDTH-1:0];
	assign kent = ent_q[KEY_WIDTH-1:0];

	// ties between the children go left
	assign up_swap  = kent < ka;
	assign dn_right = (right_w < (CW + 1)'(cnt_q)) && (kb < ka);
	assign dn_child = dn_right ? rd_b : rd_a;
	assign dn_swap  = dn_child[KEY_WIDTH-1:0] < kent;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = res_status_q;
	assign out_ident = res_ident_q;
	assign out_key   = res_key_q;
	assign occupancy = res_occ_q;

	// memory addressing and writes by state
	always_comb begin
		we = 1'b0;
		waddr = pos_q;
		wdata = ent_q;
		ra_a = '0;
		ra_b = AW'(last_w);
		pwe = 1'b0;
		pwaddr = ent_q[DW-1:KEY_WIDTH];
		pwdata = pos_q;
		unique case (state_q)
			S_LOOK2: ra_a = prd;
			S_FILL: begin
				we = 1'b1;
				pwe = 1'b1;
			end
			S_UP_RD: ra_a = parent_w;
			S_UP_CMP: begin
				// parent entry comes down into the current slot
				if (up_swap) begin
					we = 1'b1;
					wdata = rd_a;
					pwe = 1'b1;
					pwaddr = rd_a[DW-1:KEY_WIDTH];
				end
			end
			S_DN_CMP: begin
				// smaller child comes up into the current slot
				if (dn_swap) begin
					we = 1'b1;
					wdata = dn_child;
					pwe = 1'b1;
					pwaddr = dn_child[DW-1:KEY_WIDTH];
				end
			end
			S_UP_W2, S_DN_W2: begin
				we = 1'b1;
				waddr = oth_pos_q;
				pwe = 1'b1;
				pwdata = oth_pos_q;
			end
			S_DN_RD: begin
				ra_a = AW'(left_w);
				ra_b = AW'(right_w);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			present_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						kind_q <= imhq_pkg::kind_t'(kind);
						id_q <= ident;
						key_q <= KEY_WIDTH'(key);
						rid_q <= ident;
						rkey_q <= '0;
						status_q <= imhq_pkg::ST_OK;
						do_down_q <= 1'b0;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					// map read for id_q and reads of slot 0 and the last slot are in flight
					unique case (kind_q) inside
						imhq_pkg::KIND_PUSH: begin
							if (present_q[id_q]) begin
								status_q <= imhq_pkg::ST_PRESENT;
								state_q <= S_LOOK2;
							end else if (cnt_q >= CW'(CAPACITY)) begin
								status_q <= imhq_pkg::ST_FULL;
								state_q <= S_DONE;
							end else begin
								pos_q <= AW'(cnt_q);
								ent_q <= {id_q, key_q};
								rkey_q <= 32'(key_q);
								cnt_q <= cnt_q + 1'b1;
								present_q[id_q] <= 1'b1;
								state_q <= S_FILL;
							end
						end
						imhq_pkg::KIND_POP: begin
							if (cnt_q == '0) begin
								status_q <= imhq_pkg::ST_EMPTY;
								state_q <= S_DONE;
							end else begin
								pos_q <= '0;
								state_q <= S_LAST;
							end
						end
						imhq_pkg::KIND_REMOVE, imhq_pkg::KIND_DECREASE: begin
							if (!present_q[id_q]) begin
								status_q <= imhq_pkg::ST_ABSENT;
								state_q <= S_DONE;
							end else begin
								state_q <= S_LOOK2;
							end
						end
					endcase
				end
				S_LOOK2: begin
					// slot read issued on prd
					pos_q <= prd;
					state_q <= S_LAST;
				end
				S_LAST: begin
					// rd_a holds the target entry, rd_b the last entry
					if (status_q == imhq_pkg::ST_PRESENT) begin
						rkey_q <= 32'(ka);
						state_q <= S_DONE;
					end else if (kind_q == imhq_pkg::KIND_DECREASE) begin
						if (key_q >= ka) begin
							status_q <= imhq_pkg::ST_NOT_SMALLER;
							rkey_q <= 32'(ka);
							state_q <= S_DONE;
						end else begin
							ent_q <= {rd_a[DW-1:KEY_WIDTH], key_q};
							rkey_q <= 32'(key_q);
							state_q <= S_FILL;
						end
					end else begin
						// pop or remove: the last entry fills the hole
						rid_q <= rd_a[DW-1:KEY_WIDTH];
						rkey_q <= 32'(ka);
						present_q[rd_a[DW-1:KEY_WIDTH]] <= 1'b0;
						cnt_q <= cnt_q - 1'b1;
						ent_q <= rd_b;
						do_down_q <= 1'b1;
						if (CW'(pos_q) == last_w) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_FILL;
						end
					end
				end
				S_FILL: begin
					state_q <= S_UP_RD;
				end
				S_UP_RD: begin
					if (pos_q == '0) begin
						state_q <= do_down_q ? S_DN_RD : S_DONE;
					end else begin
						oth_pos_q <= parent_w;
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (up_swap) begin
						state_q <= S_UP_W2;
					end else begin
						state_q <= do_down_q ? S_DN_RD : S_DONE;
					end
				end
				S_UP_W2: begin
					pos_q <= oth_pos_q;
					state_q <= S_UP_RD;
				end
				S_DN_RD: begin
					if (left_w >= (CW + 1)'(cnt_q)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_DN_CMP;
					end
				end
				S_DN_CMP: begin
					if (dn_swap) begin
						oth_pos_q <= dn_right ? AW'(right_w) : AW'(left_w);
						state_q <= S_DN_W2;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DN_W2: begin
					pos_q <= oth_pos_q;
					state_q <= S_DN_RD;
				end
				S_DONE: begin
					// wait here while the previous result is still held
					if (out_free) begin
						res_status_q <= status_q;
						res_ident_q <= rid_q;
						res_key_q <= rkey_q;
						res_occ_q <= 7'(cnt_q);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
